[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// condition that must never be seen
`define ASSERT_NEVER(lbl, cond) `ASSERT_CLK(lbl, !(cond))
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif

`endif

[src/rct_pkg.sv]
package rct_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int ADDRESS_BITS  = 32;
    localparam int COUNT_BITS    = 16;

    typedef logic [ADDRESS_BITS-1:0] addr_t;
    typedef logic [COUNT_BITS-1:0]   count_t;

    localparam count_t COUNT_MAX = '1;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_UPDATE,
        PH_INSERT
    } phase_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_DUP  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_HOLD
    } state_t;

    // request token travelling down the cell chain
    typedef struct packed {
        logic   vld;
        phase_t phase;
        logic   pending;
        logic   dup;
        logic   has_free;
        logic   freed;
        addr_t  freed_address;
        addr_t  old_address;
        addr_t  new_address;
    } token_t;

endpackage

[src/rct_cell.sv]
`include "assert_macros.svh"

module rct_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  rct_pkg::token_t tok_in,
    output rct_pkg::token_t tok_out
);

    logic            valid_reg;
    logic            valid_next;
    rct_pkg::addr_t  address_reg;
    rct_pkg::addr_t  address_next;
    rct_pkg::count_t count_reg;
    rct_pkg::count_t count_next;
    rct_pkg::token_t tok_reg;
    rct_pkg::token_t tok_next;
    logic            hit_old;
    logic            hit_new;
    rct_pkg::count_t count_dec;
    rct_pkg::count_t count_inc;

    assign hit_old = valid_reg && (address_reg == tok_in.old_address);
    assign hit_new = valid_reg && (address_reg == tok_in.new_address);

    // decrement first, then increment, both saturating
    assign count_dec = (hit_old && count_reg != '0) ? count_reg - 1'b1 : count_reg;
    assign count_inc = (hit_new && count_dec != rct_pkg::COUNT_MAX) ?
                       count_dec + 1'b1 : count_dec;

    always_comb
    begin
        tok_next     = tok_in;
        valid_next   = valid_reg;
        address_next = address_reg;
        count_next   = count_reg;
        if (tok_in.vld)
        begin
            case (tok_in.phase)
                rct_pkg::PH_SEARCH:
                begin
                    if (hit_new)
                    begin
                        tok_next.dup = 1'b1;
                    end
                    if (!valid_reg)
                    begin
                        tok_next.has_free = 1'b1;
                    end
                end
                rct_pkg::PH_UPDATE:
                begin
                    count_next = count_inc;
                    if (hit_old && count_inc == '0)
                    begin
                        valid_next             = 1'b0;
                        address_next           = '0;
                        tok_next.freed         = 1'b1;
                        tok_next.freed_address = tok_in.old_address;
                    end
                end
                rct_pkg::PH_INSERT:
                begin
                    if (tok_in.pending && !valid_reg)
                    begin
                        valid_next       = 1'b1;
                        address_next     = tok_in.new_address;
                        count_next       = rct_pkg::COUNT_BITS'(1);
                        tok_next.pending = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            address_reg <= '0;
            count_reg   <= '0;
            tok_reg     <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            address_reg <= address_next;
            count_reg   <= count_next;
            tok_reg     <= tok_next;
        end
    end

    assign tok_out = tok_reg;

    `ASSERT_NEVER(a_live_entry_nonzero, valid_reg && count_reg == '0)
    `ASSERT_CLK(a_free_on_update, (tok_reg.vld && tok_reg.freed) |-> tok_reg.phase == rct_pkg::PH_UPDATE)

endmodule

[src/reference_count_table_unit.sv]
// Reference count table: tracks up to TABLE_ENTRIES addresses with counts.
// Input stream s_*: one request per handshake, s_tuser = kind
// (0 allocate new_address, 1 move a reference from old_address to new_address).
// Output stream m_*: one result per request, in request order; m_tuser holds
// status (ok, table full, already tracked) and the freed flag, m_tdata holds
// the freed address and the returned address.
// Each request token walks the chain of TABLE_ENTRIES cells, one cell a cycle.
// Assign: one walk; the result is captured, then loaded into the m_* register.
// Allocate: a search walk, and a second insert walk when the address is new
// and a slot is free.
// One request is in flight at a time; s_tready is high only when idle, so a
// new request is taken at the earliest in the cycle after the result is
// loaded into the output register.
// A result waits in an output register while m_tready is low; a further
// finished result waits in ST_HOLD until that register drains.
// Reset (rst_n low, asynchronous) empties the table and drops any request
// in flight; no clearing pass is needed afterwards.
`include "assert_macros.svh"

module reference_count_table_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [2*rct_pkg::ADDRESS_BITS-1:0]   s_tdata,  // old_address, new_address
    input  logic                                 s_tuser,  // kind
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [2*rct_pkg::ADDRESS_BITS-1:0]   m_tdata,  // freed_address, returned_address
    output logic [2:0]                           m_tuser   // status[1:0], freed
);

    localparam int A = rct_pkg::ADDRESS_BITS;
    localparam int N = rct_pkg::TABLE_ENTRIES;

    rct_pkg::state_t  state_reg;
    rct_pkg::state_t  state_next;
    rct_pkg::token_t  launch_tok;
    rct_pkg::token_t  chain [N];
    rct_pkg::token_t  ret_tok;
    logic [N-1:0]     tok_vld;
    logic             capture;
    logic             load_out;
    logic             out_free;
    rct_pkg::status_t res_status_c;

    rct_pkg::status_t res_status_reg;
    logic             res_freed_reg;
    rct_pkg::addr_t   res_freed_addr_reg;
    rct_pkg::addr_t   res_ret_reg;
    logic             m_tvalid_reg;
    logic [2*A-1:0]   m_tdata_reg;
    logic [2:0]       m_tuser_reg;

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            rct_pkg::token_t cell_in;
            if (i == 0)
            begin : g_head
                assign cell_in = launch_tok;
            end
            else
            begin : g_body
                assign cell_in = chain[i-1];
            end
            rct_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (cell_in),
                .tok_out (chain[i])
            );
            assign tok_vld[i] = chain[i].vld;
        end
    endgenerate

    assign ret_tok  = chain[N-1];
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next   = state_reg;
        launch_tok   = '0;
        capture      = 1'b0;
        load_out     = 1'b0;
        res_status_c = rct_pkg::STATUS_OK;
        case (state_reg)
            rct_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    launch_tok.vld         = 1'b1;
                    launch_tok.phase       = s_tuser ? rct_pkg::PH_UPDATE : rct_pkg::PH_SEARCH;
                    launch_tok.old_address = s_tdata[A-1:0];
                    launch_tok.new_address = s_tdata[2*A-1:A];
                    state_next             = rct_pkg::ST_BUSY;
                end
            end
            rct_pkg::ST_BUSY:
            begin
                if (ret_tok.vld)
                begin
                    if (ret_tok.phase == rct_pkg::PH_SEARCH && !ret_tok.dup && ret_tok.has_free)
                    begin
                        launch_tok         = ret_tok;
                        launch_tok.phase   = rct_pkg::PH_INSERT;
                        launch_tok.pending = 1'b1;
                    end
                    else
                    begin
                        capture = 1'b1;
                        if (ret_tok.phase == rct_pkg::PH_SEARCH)
                        begin
                            res_status_c = ret_tok.dup ? rct_pkg::STATUS_DUP
                                                       : rct_pkg::STATUS_FULL;
                        end
                        state_next = rct_pkg::ST_HOLD;
                    end
                end
            end
            rct_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = rct_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rct_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rct_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            res_status_reg     <= res_status_c;
            res_freed_reg      <= ret_tok.freed;
            res_freed_addr_reg <= ret_tok.freed_address;
            res_ret_reg        <= ret_tok.new_address;
        end
        if (load_out)
        begin
            m_tdata_reg <= {res_ret_reg, res_freed_addr_reg};
            m_tuser_reg <= {res_freed_reg, res_status_reg};
        end
    end

    assign s_tready = (state_reg == rct_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `ASSERT_NEVER(a_single_token, !$onehot0(tok_vld))
    `ASSERT_CLK(a_token_when_busy, (|tok_vld) |-> state_reg == rct_pkg::ST_BUSY)
    `ASSERT_CLK(a_hold_drains, (state_reg == rct_pkg::ST_HOLD && out_free) |=> m_tvalid)

endmodule

[tb/refcount_checker.sv]
`timescale 1ns / 100ps

package rct_tb_pkg;

    typedef enum logic {
        KIND_ALLOC  = 1'b0,
        KIND_ASSIGN = 1'b1
    } kind_t;

endpackage

module refcount_checker
    import rct_pkg::*;
    import rct_tb_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [2*ADDRESS_BITS-1:0]   s_tdata,  // old_address, new_address
    input  logic                        s_tuser,  // kind
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [2*ADDRESS_BITS-1:0]   m_tdata,  // freed_address, returned_address
    input  logic [2:0]                  m_tuser,  // status[1:0], freed
    output int                          errors,
    output int                          outstanding
);

    typedef struct packed {
        status_t status;
        logic    freed;
        addr_t   freed_address;
        addr_t   returned_address;
    } outcome_t;

    logic     tbl_used [TABLE_ENTRIES];
    addr_t    tbl_addr [TABLE_ENTRIES];
    count_t   tbl_refs [TABLE_ENTRIES];
    outcome_t due_results[$];
    outcome_t got;
    outcome_t want;

    function automatic int lookup(addr_t a);
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (tbl_used[i] && tbl_addr[i] == a)
                return i;
        end
        return -1;
    endfunction

    // updates the table copy and returns the result the request must produce
    function automatic outcome_t apply_request(kind_t kind, addr_t old_a, addr_t new_a);
        outcome_t r;
        int       s;
        r.status           = STATUS_OK;
        r.freed            = 1'b0;
        r.freed_address    = '0;
        r.returned_address = new_a;
        if (kind == KIND_ALLOC)
        begin
            if (lookup(new_a) >= 0)
                r.status = STATUS_DUP;
            else
            begin
                s = -1;
                for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                begin
                    if (!tbl_used[i])
                        s = i;
                end
                if (s < 0)
                    r.status = STATUS_FULL;
                else
                begin
                    tbl_used[s] = 1'b1;
                    tbl_addr[s] = new_a;
                    tbl_refs[s] = count_t'(1);
                end
            end
        end
        else
        begin
            s = lookup(old_a);
            if (s >= 0 && tbl_refs[s] != '0)
                tbl_refs[s] = tbl_refs[s] - 1'b1;
            s = lookup(new_a);
            if (s >= 0 && tbl_refs[s] != COUNT_MAX)
                tbl_refs[s] = tbl_refs[s] + 1'b1;
            // free test runs last, so old == new never frees
            s = lookup(old_a);
            if (s >= 0 && tbl_refs[s] == '0)
            begin
                tbl_used[s]     = 1'b0;
                tbl_addr[s]     = '0;
                r.freed         = 1'b1;
                r.freed_address = old_a;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                tbl_used[i] = 1'b0;
                tbl_addr[i] = '0;
                tbl_refs[i] = '0;
            end
            due_results.delete();
            errors      = 0;
            outstanding = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status           = status_t'(m_tuser[1:0]);
                got.freed            = m_tuser[2];
                got.freed_address    = m_tdata[ADDRESS_BITS-1:0];
                got.returned_address = m_tdata[2*ADDRESS_BITS-1:ADDRESS_BITS];
                if (due_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: status=%0d freed=%0b freed_address=%h returned_address=%h",
                             $time, got.status, got.freed, got.freed_address,
                             got.returned_address);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.status !== want.status || got.freed !== want.freed
                        || got.freed_address !== want.freed_address
                        || got.returned_address !== want.returned_address)
                    begin
                        errors++;
                        $display("%0t: mismatch: expected status=%0d freed=%0b freed_address=%h returned_address=%h",
                                 $time, want.status, want.freed, want.freed_address,
                                 want.returned_address);
                        $display("%0t: mismatch:   actual status=%0d freed=%0b freed_address=%h returned_address=%h",
                                 $time, got.status, got.freed, got.freed_address,
                                 got.returned_address);
                    end
                end
            end
            if (s_tvalid && s_tready)
                due_results.push_back(apply_request(kind_t'(s_tuser),
                                                    s_tdata[ADDRESS_BITS-1:0],
                                                    s_tdata[2*ADDRESS_BITS-1:ADDRESS_BITS]));
            outstanding = due_results.size();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
    import rct_pkg::*;
    import rct_tb_pkg::*;

    localparam int POOL_SIZE = 24;

    logic                        clk      = 1'b0;
    logic                        rst_n    = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tuser  = 1'b0;
    logic [2*ADDRESS_BITS-1:0]   s_tdata  = '0;
    logic                        m_tready = 1'b0;
    logic                        s_tready;
    logic                        m_tvalid;
    logic [2*ADDRESS_BITS-1:0]   m_tdata;
    logic [2:0]                  m_tuser;
    int                          errors;
    int                          outstanding;
    int                          src_idle  = 14;
    int                          sink_idle = 79;
    addr_t                       addr_pool [POOL_SIZE];

    reference_count_table_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    refcount_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= sink_idle);

    // called and returns at a falling edge
    task automatic send_request(input kind_t kind, input addr_t old_a, input addr_t new_a);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {new_a, old_a};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    function automatic addr_t pick_addr();
        if ($urandom_range(9) == 0)
            return addr_t'($urandom);
        return addr_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    // allocates draw from the pool only, so the table does not silt up
    task automatic random_request();
        if ($urandom_range(199) == 0)
            addr_pool[$urandom_range(POOL_SIZE - 1)] = addr_t'($urandom);
        if ($urandom_range(99) < 35)
            send_request(KIND_ALLOC, addr_t'($urandom),
                         addr_pool[$urandom_range(POOL_SIZE - 1)]);
        else
            send_request(KIND_ASSIGN, pick_addr(), pick_addr());
    endtask

    initial
    begin
        // pool starts with everything the directed requests leave in the table
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        addr_pool[2] = 32'hDEAD_BEEF;
        for (int i = 3; i < 18; i++)
            addr_pool[i] = 32'h1000_0000 + addr_t'(i - 2);
        for (int i = 18; i < POOL_SIZE; i++)
            addr_pool[i] = addr_t'($urandom);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request(KIND_ASSIGN, 32'h0000_0005, 32'h0000_0007);
        send_request(KIND_ALLOC, addr_t'($urandom), '0);
        send_request(KIND_ALLOC, addr_t'($urandom), '0);
        send_request(KIND_ALLOC, addr_t'($urandom), '1);
        send_request(KIND_ASSIGN, '0, '1);
        send_request(KIND_ASSIGN, '1, '1);
        for (int i = 1; i <= 15; i++)
            send_request(KIND_ALLOC, addr_t'($urandom), 32'h1000_0000 + addr_t'(i));
        send_request(KIND_ALLOC, addr_t'($urandom), 32'hDEAD_BEEF);
        send_request(KIND_ALLOC, addr_t'($urandom), '1);
        send_request(KIND_ASSIGN, 32'h1000_0001, '0);
        send_request(KIND_ALLOC, addr_t'($urandom), 32'hDEAD_BEEF);

        src_idle  = 14;
        sink_idle = 79;
        repeat (350) random_request();
        src_idle  = 79;
        sink_idle = 14;
        repeat (350) random_request();
        src_idle  = 0;
        sink_idle = 0;
        repeat (350) random_request();

        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (40) @(negedge clk);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
